// ===== rtl/core/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared codes, constants and types of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_SEND  = 3'd1;
  localparam logic [2:0] OP_ACK   = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_PROBE = 3'd4;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd30;
  localparam logic [2:0]  LAST_BIT          = 3'd7;
  localparam logic [1:0]  LAST_SUB          = 2'd2;

  // One emitted pin state
  typedef struct packed {
    logic scl;
    logic sda;
    logic hold;
    logic ack;
    logic last;
  } pin_state_t;

  // Sequencer command, from the input transfer
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data;
    logic       scl_lvl;
    logic       sda_lvl;
    logic       ack_lvl;
  } seq_cmd_t;

endpackage

// ===== rtl/core/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// i2cm_seq
// Phase sequencer: steps through the pin states of one command, one state
// per advance, shifting the byte out through a single shift register.
// ----------------------------------------------------------------------------
module i2cm_seq
  import i2cm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  seq_cmd_t   cmd_i,
  input  logic       adv_i,
  output logic       busy_o,
  output pin_state_t res_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_SEND  = 6'b000100,
    ST_ACK   = 6'b001000,
    ST_STOP  = 6'b010000,
    ST_FAIL  = 6'b100000
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [1:0] sub_q, sub_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic       probe_q, probe_d;
  logic       ack_q, ack_d;
  logic       scl_q, scl_d;
  logic       sda_q, sda_d;
  pin_state_t res;
  logic       sub_end;

  assign sub_end = (sub_q == LAST_SUB);
  assign busy_o  = (phase_q != ST_IDLE);
  assign res_o   = res;

  always_comb begin
    phase_d = phase_q;
    sub_d   = sub_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    probe_d = probe_q;
    ack_d   = ack_q;
    res     = '0;

    unique case (phase_q)
      ST_IDLE: begin
        sub_d = 2'd0;
        bit_d = 3'd0;
        if (start_i) begin
          shift_d = cmd_i.data;
          ack_d   = cmd_i.ack_lvl;
          probe_d = (cmd_i.op == OP_PROBE);
          priority case (cmd_i.op)
            OP_START: phase_d = ST_START;
            OP_SEND:  phase_d = ST_SEND;
            OP_ACK:   phase_d = ST_ACK;
            OP_STOP:  phase_d = ST_STOP;
            OP_PROBE: phase_d = (cmd_i.scl_lvl && cmd_i.sda_lvl) ? ST_START : ST_FAIL;
            default:  phase_d = ST_IDLE;  // unknown code: dropped
          endcase
        end
      end
      ST_START: begin
        res.hold = 1'b1;
        unique case (sub_q)
          2'd0:    begin res.scl = 1'b1; res.sda = 1'b1; end
          2'd1:    begin res.scl = 1'b1; res.sda = 1'b0; end
          default: begin res.scl = 1'b0; res.sda = 1'b0; end
        endcase
        res.last = sub_end && !probe_q;
      end
      ST_SEND: begin
        res.hold = 1'b1;
        unique case (sub_q)
          2'd0:    begin res.scl = scl_q; res.sda = shift_q[7]; end
          2'd1:    begin res.scl = 1'b1;  res.sda = shift_q[7]; end
          default: begin
            res.scl = 1'b0;
            res.sda = (bit_q == LAST_BIT) ? 1'b1 : shift_q[7];
          end
        endcase
        res.last = sub_end && (bit_q == LAST_BIT) && !probe_q;
      end
      ST_ACK: begin
        res.hold = 1'b1;
        res.sda  = 1'b1;
        unique case (sub_q)
          2'd0:    res.scl = scl_q;
          2'd1:    res.scl = 1'b1;
          default: res.scl = 1'b0;
        endcase
        res.ack  = sub_end ? ack_q : 1'b0;
        res.last = sub_end && !probe_q;
      end
      ST_STOP: begin
        unique case (sub_q)
          2'd0:    begin res.scl = scl_q; res.sda = 1'b0; res.hold = 1'b0; end
          2'd1:    begin res.scl = 1'b1;  res.sda = 1'b0; res.hold = 1'b1; end
          default: begin res.scl = 1'b1;  res.sda = 1'b1; res.hold = 1'b0; end
        endcase
        res.ack  = sub_end && probe_q && ack_q;
        res.last = sub_end;
      end
      ST_FAIL: begin
        // bus not free: pins unchanged, not acknowledged
        res.scl  = scl_q;
        res.sda  = sda_q;
        res.ack  = 1'b1;
        res.last = 1'b1;
      end
      default: phase_d = ST_IDLE;
    endcase

    if (adv_i && busy_o) begin
      sub_d = sub_end ? 2'd0 : sub_q + 2'd1;
      if (phase_q == ST_SEND && sub_end) begin
        shift_d = {shift_q[6:0], 1'b0};
        bit_d   = bit_q + 3'd1;
      end
      if (res.last) begin
        phase_d = ST_IDLE;
      end else if (sub_end) begin
        priority case (phase_q)
          ST_START: phase_d = ST_SEND;
          ST_SEND:  phase_d = (bit_q == LAST_BIT) ? ST_ACK : ST_SEND;
          ST_ACK:   phase_d = ST_STOP;
          default:  phase_d = ST_IDLE;
        endcase
      end
    end
  end

  assign scl_d = (adv_i && busy_o) ? res.scl : scl_q;
  assign sda_d = (adv_i && busy_o) ? res.sda : sda_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ST_IDLE;
      sub_q   <= 2'd0;
      bit_q   <= 3'd0;
      probe_q <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else begin
      phase_q <= phase_d;
      sub_q   <= sub_d;
      bit_q   <= bit_d;
      probe_q <= probe_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    ack_q   <= ack_d;
  end

endmodule

// ===== rtl/core/i2c_master_bit_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Expands I2C master commands into runs of SCL/SDA drive states.
// ----------------------------------------------------------------------------
// First pin state: through the phase register, then the output register.
// One state per cycle while the output is not stalled. States per command:
// start, wait ack, stop 3, send byte 24, probe 33 (1 if bus busy).
// Busy for the whole run; next command taken the cycle after the last state.
// Reset: SCL and SDA released high, half period 30 ticks, output empty.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
  import i2cm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic        scl_level_i,
  input  logic        sda_level_i,
  input  logic        ack_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_drive_o,
  output logic        sda_drive_o,
  output logic        hold_delay_o,
  output logic        ack_result_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic       busy;
  logic       adv;
  logic       start;
  seq_cmd_t   cmd;
  pin_state_t res;
  pin_state_t out_q, out_d;
  logic       out_valid_q, out_valid_d;

  // held for the pin timer that consumes hold_delay
  logic [15:0] half_period_q;

  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;
  assign adv        = busy && (!out_valid_q || !out_stall_i);

  assign cmd.op      = operation_i;
  assign cmd.data    = data_byte_i;
  assign cmd.scl_lvl = scl_level_i;
  assign cmd.sda_lvl = sda_level_i;
  assign cmd.ack_lvl = ack_level_i;

  i2cm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .cmd_i  (cmd),
    .adv_i  (adv),
    .busy_o (busy),
    .res_o  (res)
  );

  assign out_d       = adv ? res : out_q;
  assign out_valid_d = adv ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      half_period_q <= HALF_PERIOD_RESET;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        half_period_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign scl_drive_o  = out_q.scl;
  assign sda_drive_o  = out_q.sda;
  assign hold_delay_o = out_q.hold;
  assign ack_result_o = out_q.ack;
  assign last_o       = out_q.last;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C master bit sequencer. A queue of commands
// feeds a valid/stall driver and every accepted command is expanded into
// the pin states it must produce. A clocked monitor checks each output
// transfer against the oldest pending state. Directed cases come first,
// then random bus transactions mixed with noise, with random and long
// output stalls and several half-period settings.
// ----------------------------------------------------------------------------
module testbench
  import i2cm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int LONG_HOLD  = 300;
  localparam int SETTLE     = 8;
  localparam int IDLE_LIMIT = 1500;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  seq_cmd_t    tx_cmd    = '0;
  logic        out_stall = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  logic in_stall;
  logic out_valid;
  logic scl_drive, sda_drive, hold_delay, ack_result, last_flag;

  // bench control, changed only at clock edges
  logic tx_idle = 1'b0;
  logic rx_idle = 1'b0;
  logic long_hold_go = 1'b0;

  seq_cmd_t   cmd_q[$];
  pin_state_t pin_exp_q[$];
  logic       line_scl = 1'b1;
  logic       line_sda = 1'b1;
  int         gap_cnt  = 0;
  int         rx_wait  = 0;
  int         err_cnt  = 0;
  int         idle_cycles = 0;
  string      pin_field[5] = '{"last", "ack", "hold", "sda", "scl"};

  i2c_master_bit_sequencer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .operation_i  (tx_cmd.op),
    .data_byte_i  (tx_cmd.data),
    .scl_level_i  (tx_cmd.scl_lvl),
    .sda_level_i  (tx_cmd.sda_lvl),
    .ack_level_i  (tx_cmd.ack_lvl),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .scl_drive_o  (scl_drive),
    .sda_drive_o  (sda_drive),
    .hold_delay_o (hold_delay),
    .ack_result_o (ack_result),
    .last_o       (last_flag),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------- pin state prediction ----------------
  function automatic void emit(logic scl, logic sda, logic hold);
    pin_state_t s;
    s = '{scl: scl, sda: sda, hold: hold, ack: 1'b0, last: 1'b0};
    line_scl = scl;
    line_sda = sda;
    pin_exp_q.push_back(s);
  endfunction

  function automatic void tail_or(logic ack_v, logic last_v);
    pin_state_t s;
    s = pin_exp_q[pin_exp_q.size() - 1];
    s.ack  = s.ack | ack_v;
    s.last = s.last | last_v;
    pin_exp_q[pin_exp_q.size() - 1] = s;
  endfunction

  function automatic void emit_start();
    emit(1'b1, 1'b1, 1'b1);
    emit(1'b1, 1'b0, 1'b1);
    emit(1'b0, 1'b0, 1'b1);
  endfunction

  function automatic void emit_byte(logic [7:0] data);
    logic b;
    for (int i = 7; i >= 0; i--) begin
      b = data[i];
      emit(line_scl, b, 1'b1);
      emit(1'b1, b, 1'b1);
      // SDA is released together with the last SCL fall
      emit(1'b0, (i == 0) ? 1'b1 : b, 1'b1);
    end
  endfunction

  function automatic void emit_ack(logic ack);
    emit(line_scl, 1'b1, 1'b1);
    emit(1'b1, 1'b1, 1'b1);
    emit(1'b0, 1'b1, 1'b1);
    tail_or(ack, 1'b0);
  endfunction

  function automatic void emit_stop();
    emit(line_scl, 1'b0, 1'b0);
    emit(1'b1, 1'b0, 1'b1);
    emit(1'b1, 1'b1, 1'b0);
  endfunction

  function automatic void predict_run(seq_cmd_t c);
    case (c.op)
      OP_START: emit_start();
      OP_SEND:  emit_byte(c.data);
      OP_ACK:   emit_ack(c.ack_lvl);
      OP_STOP:  emit_stop();
      OP_PROBE: begin
        if (c.scl_lvl && c.sda_lvl) begin
          emit_start();
          emit_byte(c.data);
          emit_ack(c.ack_lvl);
          emit_stop();
          tail_or(c.ack_lvl, 1'b0);
        end else begin
          // bus busy: answer NACK, pins untouched
          emit(line_scl, line_sda, 1'b0);
          tail_or(1'b1, 1'b0);
        end
      end
      default: return;
    endcase
    tail_or(1'b0, 1'b1);
  endfunction

  // ---------------- command driver ----------------
  always @(posedge clk_i or negedge rst_ni) begin : sender
    int g;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_cnt  <= 0;
    end else begin
      g = gap_cnt;
      if (in_valid && !in_stall) begin
        predict_run(tx_cmd);
        g = tx_idle ? $urandom_range(0, 3) : 0;
      end
      if (in_valid && in_stall) begin
        // stalled transfer: keep payload and valid
      end else if (g == 0 && cmd_q.size() != 0) begin
        tx_cmd   <= cmd_q.pop_front();
        in_valid <= 1'b1;
        gap_cnt  <= 0;
      end else begin
        in_valid <= 1'b0;
        gap_cnt  <= (g == 0) ? 0 : g - 1;
      end
    end
  end

  // ---------------- result receiver ----------------
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    int n;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
    end else begin
      n = rx_wait;
      if (long_hold_go)
        n = LONG_HOLD;
      else if (out_valid && !out_stall)
        n = rx_idle ? $urandom_range(0, 3) : 0;
      else if (n > 0)
        n = n - 1;
      out_stall <= (n != 0);
      rx_wait   <= n;
    end
  end

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin : monitor
    pin_state_t got, want;
    if (rst_ni && out_valid && !out_stall) begin
      got = '{scl: scl_drive, sda: sda_drive, hold: hold_delay,
              ack: ack_result, last: last_flag};
      if (pin_exp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected pin state %05b", got));
      end else begin
        want = pin_exp_q.pop_front();
        for (int i = 0; i < 5; i++) begin
          if (got[i] !== want[i])
            report_mismatch($sformatf("%s got %b expected %b",
                                      pin_field[i], got[i], want[i]));
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic int queue_cmd(logic [2:0] op, logic [7:0] data, logic [2:0] lv);
    seq_cmd_t c;
    c = '{op: op, data: data, scl_lvl: lv[2], sda_lvl: lv[1], ack_lvl: lv[0]};
    cmd_q.push_back(c);
    return (op <= OP_PROBE) ? 1 : 0;
  endfunction

  function automatic logic [2:0] rnd_lv();
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly complete write transactions, some probes, noise and cut-off runs
  task automatic gen_items(int n);
    int made;
    int pick;
    int k;
    logic [2:0] lv;
    made = 0;
    @(negedge clk_i);
    while (made < n) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        made += queue_cmd(OP_START, rnd_byte(), rnd_lv());
        made += queue_cmd(OP_SEND, {rnd_byte()}, rnd_lv());
        made += queue_cmd(OP_ACK, rnd_byte(), rnd_lv());
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) begin
          made += queue_cmd(OP_SEND, rnd_byte(), rnd_lv());
          made += queue_cmd(OP_ACK, rnd_byte(), rnd_lv());
        end
        made += queue_cmd(OP_STOP, rnd_byte(), rnd_lv());
      end else if (pick <= 7) begin
        lv = rnd_lv();
        if ($urandom_range(0, 3) != 0)
          lv[2:1] = 2'b11;
        made += queue_cmd(OP_PROBE, {rnd_byte()}, lv);
      end else if (pick == 8) begin
        made += queue_cmd(3'($urandom_range(0, 7)), rnd_byte(), rnd_lv());
      end else begin
        made += queue_cmd(OP_START, rnd_byte(), rnd_lv());
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
          made += queue_cmd(3'($urandom_range(0, 4)), rnd_byte(), rnd_lv());
      end
    end
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    while (cmd_q.size() != 0 || in_valid || pin_exp_q.size() != 0)
      @(negedge clk_i);
    // ignored commands leave nothing to wait on, give the block time
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [15:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_idling(logic tx, logic rx);
    @(posedge clk_i);
    tx_idle <= tx;
    rx_idle <= rx;
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_cfg(16'd1);

    // directed: every operation, byte extremes, busy-bus probes, bad opcodes
    @(negedge clk_i);
    void'(queue_cmd(OP_START, 8'h00, 3'b000));
    void'(queue_cmd(OP_SEND,  8'h00, 3'b000));
    void'(queue_cmd(OP_ACK,   8'h00, 3'b110));
    void'(queue_cmd(OP_SEND,  8'hFF, 3'b111));
    void'(queue_cmd(OP_ACK,   8'hFF, 3'b001));
    void'(queue_cmd(OP_SEND,  8'hA5, 3'b010));
    void'(queue_cmd(OP_STOP,  8'h5A, 3'b101));
    void'(queue_cmd(OP_STOP,  8'h00, 3'b000));
    void'(queue_cmd(OP_ACK,   8'h00, 3'b000));
    void'(queue_cmd(OP_PROBE, 8'hA0, 3'b110));
    void'(queue_cmd(OP_PROBE, 8'hFE, 3'b111));
    void'(queue_cmd(OP_PROBE, 8'h42, 3'b010));
    void'(queue_cmd(OP_PROBE, 8'h42, 3'b101));
    void'(queue_cmd(OP_PROBE, 8'h00, 3'b000));
    for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
      void'(queue_cmd(3'(op), 8'hFF, 3'b111));
    void'(queue_cmd(OP_START, 8'h00, 3'b111));
    void'(queue_cmd(OP_PROBE, 8'h80, 3'b011));
    void'(queue_cmd(OP_SEND,  8'h80, 3'b000));
    void'(queue_cmd(OP_START, 8'h00, 3'b000));
    void'(queue_cmd(OP_SEND,  8'h01, 3'b100));
    void'(queue_cmd(OP_STOP,  8'h00, 3'b000));
    void'(queue_cmd(OP_START, 8'h00, 3'b000));
    void'(queue_cmd(OP_START, 8'h00, 3'b000));
    void'(queue_cmd(OP_STOP,  8'h00, 3'b000));
    wait_drain();

    // random gaps on both sides plus one long output hold
    write_cfg(16'hFFFF);
    set_idling(1'b1, 1'b1);
    gen_items(110);
    @(negedge clk_i);
    while (cmd_q.size() > 60)
      @(negedge clk_i);
    @(posedge clk_i);
    long_hold_go <= 1'b1;
    @(posedge clk_i);
    long_hold_go <= 1'b0;
    wait_drain();

    // back to back, no idling
    write_cfg(HALF_PERIOD_RESET);
    set_idling(1'b0, 1'b0);
    gen_items(90);
    wait_drain();

    write_cfg(16'($urandom_range(1, 65535)));
    set_idling(1'b1, 1'b0);
    gen_items(50);
    wait_drain();
    set_idling(1'b0, 1'b1);
    gen_items(50);
    wait_drain();

    if (pin_exp_q.size() != 0)
      report_mismatch($sformatf("%0d pin states never arrived", pin_exp_q.size()));
    if (err_cnt == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
